>>> rtl/core/assert_macros.svh
// Assertion macros shared by the queue, front and back modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked once out of reset.
`define CHTE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked once out of reset.
`define CHTE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/chte_pkg.sv
// Shared types and constants of the cubic Hermite table evaluator.
`default_nettype none

package chte_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int COEF_W    = 48;
    localparam int FRAC_W    = FRAC_BITS + 1;
    localparam int IV_W      = 10;
    localparam int CNT_W     = 11;

    localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    localparam logic [1:0] REG_MIN_ARG   = 2'd0;
    localparam logic [1:0] REG_STEP_SIZE = 2'd1;
    localparam logic [1:0] REG_STEP_INV  = 2'd2;
    localparam logic [1:0] REG_INTERVALS = 2'd3;

    // Row of one interval: [0] = c0 ... [3] = c3
    typedef logic [3:0][COEF_W-1:0] coef_row_t;

    typedef struct packed {
        logic              kind;
        logic              oor;
        logic [FRAC_W-1:0] frac;
    } tag_t;

    typedef struct packed {
        logic [DATA_W-1:0] min_arg;
        logic [DATA_W-1:0] step_size;
        logic [DATA_W-1:0] step_inv;
        logic [CNT_W-1:0]  intervals_in_use;
    } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/chte_fifo.sv
// Short queue between the front and back sections.
`default_nettype none
`include "assert_macros.svh"

module chte_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] din,
    output logic              wr_ready,
    input  wire logic         pop,
    output logic [W-1:0]      dout,
    output logic              rd_valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  store [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign dout     = store[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `CHTE_ASSERT_IMP(a_no_push_full, push, count_reg != CW'(DEPTH), "push into full queue")
    `CHTE_ASSERT_IMP(a_no_pop_empty, pop, count_reg != '0, "pop from empty queue")
    `CHTE_ASSERT_NXT(a_room_after_pop, pop && !push, wr_ready, "no room after pop")

endmodule

`default_nettype wire

>>> rtl/core/chte_front.sv
// Front section: accepts items, scales arguments, builds load coefficients.
`default_nettype none
`include "assert_macros.svh"

module chte_front
    import chte_pkg::*;
#(
    parameter int TABLE_INTERVALS = 1024,
    parameter int IW              = 10
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cfg_t                cfg,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                in_kind,
    input  wire logic [DATA_W-1:0]   in_arg,
    input  wire logic [IV_W-1:0]     in_interval,
    input  wire logic [DATA_W-1:0]   in_left_value,
    input  wire logic [DATA_W-1:0]   in_left_slope,
    input  wire logic [DATA_W-1:0]   in_right_value,
    input  wire logic [DATA_W-1:0]   in_right_slope,
    output logic                     q_push,
    input  wire logic                q_ready,
    output tag_t                     q_tag,
    output logic [IW-1:0]            q_idx,
    output coef_row_t                q_coef
);

    localparam int OPA_W  = DATA_W + 1;
    localparam int S2_W   = DATA_W + 2;
    localparam int PROD_W = 2 * OPA_W;
    localparam int PM0_W  = DATA_W + OPA_W;
    localparam int PS2_W  = S2_W + OPA_W;
    localparam int SAT_W  = COEF_W + 4;
    localparam int NW     = 17;
    localparam int IPW    = PROD_W - DATA_W;
    localparam logic [NW-1:0] TBL_N = NW'(TABLE_INTERVALS);
    localparam logic [COEF_W-1:0] C_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] C_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    function automatic logic [COEF_W-1:0] sat_coef(input logic signed [SAT_W-1:0] v);
        logic [SAT_W-COEF_W:0] top;
        begin
            top = v[SAT_W-1:COEF_W-1];
            if (top == '0 || top == '1)
            begin
                sat_coef = v[COEF_W-1:0];
            end
            else
            begin
                sat_coef = v[SAT_W-1] ? C_MIN : C_MAX;
            end
        end
    endfunction

    logic en;

    // stage 1
    logic                     s1_v_reg;
    logic                     s1_kind_reg;
    logic signed [OPA_W-1:0]  s1_opa_reg;
    logic signed [DATA_W-1:0] s1_y0_reg;
    logic signed [OPA_W-1:0]  s1_d_reg;
    logic signed [S2_W-1:0]   s1_s2_reg;
    logic signed [DATA_W-1:0] s1_m0_reg;
    logic [IV_W-1:0]          s1_iv_reg;
    logic signed [OPA_W-1:0]  s1_opa_next;

    // stage 2
    logic                     s2_v_reg;
    logic                     s2_kind_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;
    logic signed [PM0_W-1:0]  s2_pm0_reg;
    logic signed [PS2_W-1:0]  s2_ps2_reg;
    logic signed [DATA_W-1:0] s2_y0_reg;
    logic signed [OPA_W-1:0]  s2_d_reg;
    logic [IV_W-1:0]          s2_iv_reg;
    logic signed [OPA_W-1:0]  opb;
    logic signed [OPA_W-1:0]  h_s;

    // stage 3
    logic                     s3_v_reg;
    tag_t                     s3_tag_reg;
    logic [IW-1:0]            s3_idx_reg;
    coef_row_t                s3_coef_reg;
    logic                     s3_v_next;
    tag_t                     s3_tag_next;
    logic [IW-1:0]            s3_idx_next;
    coef_row_t                s3_coef_next;

    logic [NW-1:0]            n_eff;
    logic [NW-1:0]            n_m1;
    logic [IPW-1:0]           ip;
    logic                     pos_neg;
    logic                     above;
    logic                     load_ok;
    logic [IW+IV_W-1:0]       iv_ext;
    logic signed [SAT_W-1:0]  d_x;
    logic signed [PM0_W-FRAC_BITS-1:0]  sh_m0;
    logic signed [PS2_W-FRAC_BITS-1:0]  sh_s2;
    logic signed [PROD_W-FRAC_BITS-1:0] sh_s1;

    assign en       = !s3_v_reg || q_ready;
    assign in_ready = en;
    assign q_push   = s3_v_reg && q_ready;
    assign q_tag    = s3_tag_reg;
    assign q_idx    = s3_idx_reg;
    assign q_coef   = s3_coef_reg;

    always_comb
    begin
        if (in_kind == KIND_EVAL)
        begin
            s1_opa_next = OPA_W'($signed(in_arg)) - OPA_W'($signed(cfg.min_arg));
        end
        else
        begin
            s1_opa_next = OPA_W'($signed(in_left_slope)) + OPA_W'($signed(in_right_slope));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_kind_reg <= in_kind;
            s1_opa_reg  <= s1_opa_next;
            s1_y0_reg   <= $signed(in_left_value);
            s1_d_reg    <= OPA_W'($signed(in_right_value)) - OPA_W'($signed(in_left_value));
            s1_s2_reg   <= S2_W'($signed(in_left_slope)) + S2_W'($signed(in_left_slope))
                         + S2_W'($signed(in_right_slope));
            s1_m0_reg   <= $signed(in_left_slope);
            s1_iv_reg   <= in_interval;
        end
    end

    // one shared 33x33 product: argument scaling or (m0 + m1) * h
    assign h_s = $signed({1'b0, cfg.step_size});
    assign opb = (s1_kind_reg == KIND_EVAL) ? $signed({1'b0, cfg.step_inv}) : h_s;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_kind_reg <= s1_kind_reg;
            s2_prod_reg <= PROD_W'(s1_opa_reg) * PROD_W'(opb);
            s2_pm0_reg  <= PM0_W'(s1_m0_reg) * PM0_W'(h_s);
            s2_ps2_reg  <= PS2_W'(s1_s2_reg) * PS2_W'(h_s);
            s2_y0_reg   <= s1_y0_reg;
            s2_d_reg    <= s1_d_reg;
            s2_iv_reg   <= s1_iv_reg;
        end
    end

    always_comb
    begin
        n_eff = (cfg.intervals_in_use == '0) ? NW'(1) : NW'(cfg.intervals_in_use);
        if (n_eff > TBL_N)
        begin
            n_eff = TBL_N;
        end
        n_m1    = n_eff - 1'b1;
        pos_neg = s2_prod_reg[PROD_W-1];
        ip      = s2_prod_reg[PROD_W-1:DATA_W];
        above   = !pos_neg && (ip >= IPW'(n_eff));
        load_ok = (NW'(s2_iv_reg) < TBL_N);
        iv_ext  = {{IW{1'b0}}, s2_iv_reg};

        sh_m0 = $signed(s2_pm0_reg[PM0_W-1:FRAC_BITS]);
        sh_s2 = $signed(s2_ps2_reg[PS2_W-1:FRAC_BITS]);
        sh_s1 = $signed(s2_prod_reg[PROD_W-1:FRAC_BITS]);
        d_x   = SAT_W'(s2_d_reg);

        s3_coef_next[0] = COEF_W'(s2_y0_reg);
        s3_coef_next[1] = sat_coef(SAT_W'(sh_m0));
        s3_coef_next[2] = sat_coef(d_x + (d_x <<< 1) - SAT_W'(sh_s2));
        s3_coef_next[3] = sat_coef(SAT_W'(sh_s1) - (d_x <<< 1));

        s3_tag_next.kind = s2_kind_reg;
        s3_tag_next.oor  = 1'b0;
        s3_tag_next.frac = {1'b0, s2_prod_reg[DATA_W-1:FRAC_BITS]};
        s3_idx_next      = ip[IW-1:0];
        if (s2_kind_reg == KIND_LOAD)
        begin
            s3_idx_next = iv_ext[IW-1:0];
        end
        else if (pos_neg)
        begin
            s3_tag_next.oor  = 1'b1;
            s3_tag_next.frac = '0;
            s3_idx_next      = '0;
        end
        else if (above)
        begin
            s3_tag_next.oor  = 1'b1;
            s3_tag_next.frac = FRAC_ONE;
            s3_idx_next      = n_m1[IW-1:0];
        end

        // loads beyond the table are dropped here
        s3_v_next = s2_v_reg && ((s2_kind_reg == KIND_EVAL) || load_ok);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_tag_reg  <= s3_tag_next;
            s3_idx_reg  <= s3_idx_next;
            s3_coef_reg <= s3_coef_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s3_v_next;
        end
    end

    `CHTE_ASSERT_IMP(a_end_clamped, q_push && q_tag.kind == KIND_EVAL && q_tag.frac == FRAC_ONE, q_tag.oor, "full fraction without clamp")

endmodule

`default_nettype wire

>>> rtl/core/chte_back.sv
// Back section: coefficient table and Horner evaluation pipeline.
`default_nettype none
`include "assert_macros.svh"

module chte_back
    import chte_pkg::*;
#(
    parameter int TABLE_INTERVALS = 1024,
    parameter int IW              = 10
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    output logic                   q_pop,
    input  wire tag_t              q_tag,
    input  wire logic [IW-1:0]     q_idx,
    input  wire coef_row_t         q_coef,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DATA_W-1:0]      out_value,
    output logic                   out_oor,
    output logic                   out_sat
);

    localparam int FS_W = FRAC_W + 1;
    localparam int A1_W = COEF_W + 1;
    localparam int A2_W = COEF_W + 2;
    localparam int A3_W = COEF_W + 3;
    localparam int P3_W = COEF_W + FS_W;
    localparam int P2_W = A1_W + FS_W;
    localparam int P1_W = A2_W + FS_W;
    localparam logic [DATA_W-1:0] V_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] V_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    coef_row_t coef_mem [TABLE_INTERVALS];

    logic en;
    logic wr_en;
    logic rd_en;

    logic                     b1_v_reg;
    coef_row_t                b1_row_reg;
    logic [FRAC_W-1:0]        b1_frac_reg;
    logic                     b1_oor_reg;
    logic signed [FS_W-1:0]   b1_fs;

    logic                     b2_v_reg;
    logic signed [P3_W-1:0]   b2_p3_reg;
    logic signed [COEF_W-1:0] b2_c2_reg;
    logic signed [COEF_W-1:0] b2_c1_reg;
    logic signed [COEF_W-1:0] b2_c0_reg;
    logic signed [FS_W-1:0]   b2_fs_reg;
    logic                     b2_oor_reg;

    logic                     b3_v_reg;
    logic signed [A1_W-1:0]   b3_a1_reg;
    logic signed [COEF_W-1:0] b3_c1_reg;
    logic signed [COEF_W-1:0] b3_c0_reg;
    logic signed [FS_W-1:0]   b3_fs_reg;
    logic                     b3_oor_reg;

    logic                     b4_v_reg;
    logic signed [P2_W-1:0]   b4_p2_reg;
    logic signed [COEF_W-1:0] b4_c1_reg;
    logic signed [COEF_W-1:0] b4_c0_reg;
    logic signed [FS_W-1:0]   b4_fs_reg;
    logic                     b4_oor_reg;

    logic                     b5_v_reg;
    logic signed [A2_W-1:0]   b5_a2_reg;
    logic signed [COEF_W-1:0] b5_c0_reg;
    logic signed [FS_W-1:0]   b5_fs_reg;
    logic                     b5_oor_reg;

    logic                     b6_v_reg;
    logic signed [P1_W-1:0]   b6_p1_reg;
    logic signed [COEF_W-1:0] b6_c0_reg;
    logic                     b6_oor_reg;

    logic                     b7_v_reg;
    logic signed [A3_W-1:0]   b7_a3_reg;
    logic                     b7_oor_reg;

    logic                     out_v_reg;
    logic [DATA_W-1:0]        out_value_reg;
    logic                     out_oor_reg;
    logic                     out_sat_reg;

    logic signed [COEF_W-1:0] sh3;
    logic signed [A1_W-1:0]   sh2;
    logic signed [A2_W-1:0]   sh1;
    logic [A3_W-DATA_W:0]     a3_top;
    logic                     sat_next;
    logic [DATA_W-1:0]        value_next;

    assign en    = !out_v_reg || out_ready;
    assign q_pop = en && q_valid;
    assign wr_en = q_pop && (q_tag.kind == KIND_LOAD);
    assign rd_en = q_pop && (q_tag.kind == KIND_EVAL);

    assign out_valid = out_v_reg;
    assign out_value = out_value_reg;
    assign out_oor   = out_oor_reg;
    assign out_sat   = out_sat_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            coef_mem[q_idx] <= q_coef;
        end
        if (rd_en)
        begin
            b1_row_reg <= coef_mem[q_idx];
        end
    end

    assign b1_fs = $signed({1'b0, b1_frac_reg});
    assign sh3   = $signed(b2_p3_reg[COEF_W+FRAC_BITS-1:FRAC_BITS]);
    assign sh2   = $signed(b4_p2_reg[A1_W+FRAC_BITS-1:FRAC_BITS]);
    assign sh1   = $signed(b6_p1_reg[A2_W+FRAC_BITS-1:FRAC_BITS]);

    always_comb
    begin
        a3_top = b7_a3_reg[A3_W-1:DATA_W-1];
        if (a3_top == '0 || a3_top == '1)
        begin
            sat_next   = 1'b0;
            value_next = b7_a3_reg[DATA_W-1:0];
        end
        else
        begin
            sat_next   = 1'b1;
            value_next = b7_a3_reg[A3_W-1] ? V_MIN : V_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_frac_reg   <= q_tag.frac;
            b1_oor_reg    <= q_tag.oor;

            b2_p3_reg     <= P3_W'($signed(b1_row_reg[3])) * P3_W'(b1_fs);
            b2_c2_reg     <= $signed(b1_row_reg[2]);
            b2_c1_reg     <= $signed(b1_row_reg[1]);
            b2_c0_reg     <= $signed(b1_row_reg[0]);
            b2_fs_reg     <= b1_fs;
            b2_oor_reg    <= b1_oor_reg;

            b3_a1_reg     <= A1_W'(b2_c2_reg) + A1_W'(sh3);
            b3_c1_reg     <= b2_c1_reg;
            b3_c0_reg     <= b2_c0_reg;
            b3_fs_reg     <= b2_fs_reg;
            b3_oor_reg    <= b2_oor_reg;

            b4_p2_reg     <= P2_W'(b3_a1_reg) * P2_W'(b3_fs_reg);
            b4_c1_reg     <= b3_c1_reg;
            b4_c0_reg     <= b3_c0_reg;
            b4_fs_reg     <= b3_fs_reg;
            b4_oor_reg    <= b3_oor_reg;

            b5_a2_reg     <= A2_W'(b4_c1_reg) + A2_W'(sh2);
            b5_c0_reg     <= b4_c0_reg;
            b5_fs_reg     <= b4_fs_reg;
            b5_oor_reg    <= b4_oor_reg;

            b6_p1_reg     <= P1_W'(b5_a2_reg) * P1_W'(b5_fs_reg);
            b6_c0_reg     <= b5_c0_reg;
            b6_oor_reg    <= b5_oor_reg;

            b7_a3_reg     <= A3_W'(b6_c0_reg) + A3_W'(sh1);
            b7_oor_reg    <= b6_oor_reg;

            out_value_reg <= value_next;
            out_oor_reg   <= b7_oor_reg;
            out_sat_reg   <= sat_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg  <= 1'b0;
            b2_v_reg  <= 1'b0;
            b3_v_reg  <= 1'b0;
            b4_v_reg  <= 1'b0;
            b5_v_reg  <= 1'b0;
            b6_v_reg  <= 1'b0;
            b7_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_v_reg  <= rd_en;
            b2_v_reg  <= b1_v_reg;
            b3_v_reg  <= b2_v_reg;
            b4_v_reg  <= b3_v_reg;
            b5_v_reg  <= b4_v_reg;
            b6_v_reg  <= b5_v_reg;
            b7_v_reg  <= b6_v_reg;
            out_v_reg <= b7_v_reg;
        end
    end

    `CHTE_ASSERT_IMP(a_sat_extreme, out_v_reg && out_sat_reg, out_value_reg == V_MAX || out_value_reg == V_MIN, "saturated value not at a limit")

endmodule

`default_nettype wire

>>> rtl/core/cubic_hermite_table_eval_top.sv
// Top level of the uniform cubic Hermite table evaluator.
// Evaluate: an item passes s1-s3, the queue, b1-b7 and the output register.
// One item per cycle while m_tready holds; loads take a slot and give no result.
// Rate is set by the shared argument multiplier and the single table port.
// Reset clears valid flags and presets config; table is undefined until loaded.
`default_nettype none

module cubic_hermite_table_eval_top
    import chte_pkg::*;
#(
    parameter int TABLE_INTERVALS = 1024,
    parameter int QUEUE_DEPTH     = 4
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // arg, interval, left_value, left_slope, right_value, right_slope, zero pad
    input  wire logic [175:0] s_tdata,
    // kind
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // value
    output logic [31:0]       m_tdata,
    // out_of_range, saturated
    output logic [1:0]        m_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int IW     = (TABLE_INTERVALS > 1) ? $clog2(TABLE_INTERVALS) : 1;
    localparam int ITEM_W = $bits(tag_t) + IW + $bits(coef_row_t);

    cfg_t cfg_reg;
    logic cfg_wr;

    logic              q_push;
    logic              q_wr_ready;
    tag_t              f_tag;
    logic [IW-1:0]     f_idx;
    coef_row_t         f_coef;
    logic              q_pop;
    logic              q_valid;
    logic [ITEM_W-1:0] q_dout;
    tag_t              b_tag;
    logic [IW-1:0]     b_idx;
    coef_row_t         b_coef;
    logic              b_oor;
    logic              b_sat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_arg          <= '0;
            cfg_reg.step_size        <= 32'h0001_0000;
            cfg_reg.step_inv         <= 32'h0001_0000;
            cfg_reg.intervals_in_use <= 11'd1024;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_MIN_ARG:   cfg_reg.min_arg          <= pwdata;
                REG_STEP_SIZE: cfg_reg.step_size        <= pwdata;
                REG_STEP_INV:  cfg_reg.step_inv         <= pwdata;
                REG_INTERVALS: cfg_reg.intervals_in_use <= pwdata[CNT_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MIN_ARG:   prdata = cfg_reg.min_arg;
            REG_STEP_SIZE: prdata = cfg_reg.step_size;
            REG_STEP_INV:  prdata = cfg_reg.step_inv;
            REG_INTERVALS: prdata = {{(32-CNT_W){1'b0}}, cfg_reg.intervals_in_use};
        endcase
    end

    chte_front #(
        .TABLE_INTERVALS(TABLE_INTERVALS),
        .IW             (IW)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_kind       (s_tuser[0]),
        .in_arg        (s_tdata[31:0]),
        .in_interval   (s_tdata[41:32]),
        .in_left_value (s_tdata[73:42]),
        .in_left_slope (s_tdata[105:74]),
        .in_right_value(s_tdata[137:106]),
        .in_right_slope(s_tdata[169:138]),
        .q_push        (q_push),
        .q_ready       (q_wr_ready),
        .q_tag         (f_tag),
        .q_idx         (f_idx),
        .q_coef        (f_coef)
    );

    chte_fifo #(
        .W    (ITEM_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .din     ({f_tag, f_idx, f_coef}),
        .wr_ready(q_wr_ready),
        .pop     (q_pop),
        .dout    (q_dout),
        .rd_valid(q_valid)
    );

    assign {b_tag, b_idx, b_coef} = q_dout;

    chte_back #(
        .TABLE_INTERVALS(TABLE_INTERVALS),
        .IW             (IW)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_tag    (b_tag),
        .q_idx    (b_idx),
        .q_coef   (b_coef),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_value(m_tdata),
        .out_oor  (b_oor),
        .out_sat  (b_sat)
    );

    assign m_tuser = {b_sat, b_oor};

endmodule

`default_nettype wire
